FILE: hdl/dsc_pkg.sv
package dsc_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_HASH,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

    localparam logic [2:0] ST_NOT_DISCOVERY = 3'd0;
    localparam logic [2:0] ST_BAD_FORMAT    = 3'd1;
    localparam logic [2:0] ST_CRC_ERROR     = 3'd2;
    localparam logic [2:0] ST_BAD_SLOTS     = 3'd3;
    localparam logic [2:0] ST_DUPLICATE     = 3'd4;
    localparam logic [2:0] ST_ACCEPTED      = 3'd5;

    localparam logic [7:0] HDR0        = 8'hAA;
    localparam logic [7:0] HDR1        = 8'h55;
    localparam logic [7:0] VER_OK      = 8'h01;
    localparam logic [7:0] CMD_REQ     = 8'h01;
    localparam logic [7:0] PAYLOAD_LEN = 8'h05;

    localparam logic [3:0] REQ_LEN   = 4'd12;
    localparam logic [3:0] COUNT_MAX = 4'd15;
    localparam logic [4:0] ALL_FLAGS = 5'h1F;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [3:0] HASH_LAST = 4'd7;
    localparam logic [3:0] DIV_LAST  = 4'd15;

endpackage

FILE: hdl/dsc_crc_unit.sv
module dsc_crc_unit
    import dsc_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        o_crc = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            o_crc = o_crc[0] ? ((o_crc >> 1) ^ CRC_POLY) : (o_crc >> 1);
        end
    end

endmodule

FILE: hdl/discovery_request_slot_checker_core.sv
// Discovery request slot checker.
// Input channel: one frame byte per beat on i_data_byte, with i_frame_end high
// on the last byte, under i_valid and o_ready. Output channel: one result beat
// per frame under o_valid and i_ready, carrying status, nonce, slot, delay and
// the generation count. The MAC is written through i_cfg_we and i_cfg_data.
// Bytes that do not end a frame are taken one per cycle and may arrive back to back.
// After the last byte the block drops o_ready: a rejected frame goes from the
// classify state straight to its result, and an accepted frame passes through
// the classify state, eight passes of the shared CRC byte unit over the MAC and
// nonce, the bit-serial modulo and the multiply step before its result.
// The result stays in its output register while the receiver stalls, and the
// block takes no byte until that beat is taken; it is ready again the cycle after.
// A synchronous active-low reset clears the frame state, the stored nonce, the
// generation count and the MAC.
module discovery_request_slot_checker_core
    import dsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_nonce,
    output logic [7:0]  o_slot,
    output logic [23:0] o_delay_ms,
    output logic [31:0] o_generation
);

    t_state r_state, n_state;
    logic [47:0] r_mac;
    logic [3:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_held0, n_held0, r_held1, n_held1;
    logic [4:0]  r_flags, n_flags;
    logic [15:0] r_nonce, n_nonce;
    logic [7:0]  r_slot_count, n_slot_count;
    logic [15:0] r_duration, n_duration;
    logic [15:0] r_last_nonce, n_last_nonce;
    logic        r_last_valid, n_last_valid;
    logic [31:0] r_accept, n_accept;
    logic [3:0]  r_cnt, n_cnt;
    logic [7:0]  r_rem, n_rem;
    logic [2:0]  r_o_status, n_o_status;
    logic [15:0] r_o_nonce, n_o_nonce;
    logic [7:0]  r_o_slot, n_o_slot;
    logic [23:0] r_o_delay, n_o_delay;
    logic [31:0] r_o_gen, n_o_gen;

    logic        in_beat, out_beat;
    logic [2:0]  status_c;
    logic [7:0]  hash_byte, crc_byte;
    logic [15:0] crc_out;
    logic [8:0]  rem_sh;

    assign in_beat  = i_valid && o_ready;
    assign out_beat = o_valid && i_ready;

    always_comb begin
        case (r_cnt[2:0])
            3'd0:    hash_byte = r_mac[47:40];
            3'd1:    hash_byte = r_mac[39:32];
            3'd2:    hash_byte = r_mac[31:24];
            3'd3:    hash_byte = r_mac[23:16];
            3'd4:    hash_byte = r_mac[15:8];
            3'd5:    hash_byte = r_mac[7:0];
            3'd6:    hash_byte = r_nonce[15:8];
            default: hash_byte = r_nonce[7:0];
        endcase
    end

    assign crc_byte = (r_state == S_HASH) ? hash_byte : r_held0;

    dsc_crc_unit u_crc (
        .i_crc  (r_crc),
        .i_byte (crc_byte),
        .o_crc  (crc_out)
    );

    always_comb begin
        if (r_count < 4'd2 || r_flags[1:0] != 2'b11) begin
            status_c = ST_NOT_DISCOVERY;
        end else if (r_count != REQ_LEN || r_flags != ALL_FLAGS) begin
            status_c = ST_BAD_FORMAT;
        end else if ({r_held1, r_held0} != r_crc) begin
            status_c = ST_CRC_ERROR;
        end else if (r_slot_count == 8'd0 || r_duration == 16'd0) begin
            status_c = ST_BAD_SLOTS;
        end else if (r_last_valid && r_nonce == r_last_nonce) begin
            status_c = ST_DUPLICATE;
        end else begin
            status_c = ST_ACCEPTED;
        end
    end

    assign rem_sh = {r_rem, r_crc[15]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (in_beat && i_frame_end) n_state = S_CLASSIFY;
            S_CLASSIFY: n_state = (status_c == ST_ACCEPTED) ? S_HASH : S_OUT;
            S_HASH:     if (r_cnt == HASH_LAST) n_state = S_DIV;
            S_DIV:      if (r_cnt == DIV_LAST) n_state = S_MUL;
            S_MUL:      n_state = S_OUT;
            S_OUT:      if (out_beat) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_valid = (r_state == S_OUT);
    end

    always_comb begin
        n_count      = r_count;
        n_crc        = r_crc;
        n_held0      = r_held0;
        n_held1      = r_held1;
        n_flags      = r_flags;
        n_nonce      = r_nonce;
        n_slot_count = r_slot_count;
        n_duration   = r_duration;
        n_last_nonce = r_last_nonce;
        n_last_valid = r_last_valid;
        n_accept     = r_accept;
        n_cnt        = r_cnt;
        n_rem        = r_rem;
        n_o_status   = r_o_status;
        n_o_nonce    = r_o_nonce;
        n_o_slot     = r_o_slot;
        n_o_delay    = r_o_delay;
        n_o_gen      = r_o_gen;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    case (r_count)
                        4'd0:    if (i_data_byte == HDR0) n_flags[0] = 1'b1;
                        4'd1:    if (i_data_byte == HDR1) n_flags[1] = 1'b1;
                        4'd2:    if (i_data_byte == VER_OK) n_flags[2] = 1'b1;
                        4'd3:    if (i_data_byte == CMD_REQ) n_flags[3] = 1'b1;
                        4'd4:    if (i_data_byte == PAYLOAD_LEN) n_flags[4] = 1'b1;
                        4'd5:    n_nonce[15:8] = i_data_byte;
                        4'd6:    n_nonce[7:0] = i_data_byte;
                        4'd7:    n_slot_count = i_data_byte;
                        4'd8:    n_duration[15:8] = i_data_byte;
                        4'd9:    n_duration[7:0] = i_data_byte;
                        default: ;
                    endcase
                    if (r_count >= 4'd2) n_crc = crc_out;
                    n_held0 = r_held1;
                    n_held1 = i_data_byte;
                    if (r_count != COUNT_MAX) n_count = r_count + 4'd1;
                end
            end
            S_CLASSIFY: begin
                n_o_status = status_c;
                n_o_nonce  = 16'd0;
                n_o_slot   = 8'd0;
                n_o_delay  = 24'd0;
                n_o_gen    = r_accept;
                if (status_c == ST_ACCEPTED) begin
                    n_last_nonce = r_nonce;
                    n_last_valid = 1'b1;
                    n_accept     = r_accept + 32'd1;
                    n_o_gen      = r_accept + 32'd1;
                    n_crc        = CRC_INIT;
                    n_cnt        = 4'd0;
                end
            end
            S_HASH: begin
                n_crc = crc_out;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == HASH_LAST) begin
                    n_cnt = 4'd0;
                    n_rem = 8'd0;
                end
            end
            S_DIV: begin
                n_crc = {r_crc[14:0], 1'b0};
                n_cnt = r_cnt + 4'd1;
                if (rem_sh >= {1'b0, r_slot_count}) begin
                    n_rem = 8'(rem_sh - {1'b0, r_slot_count});
                end else begin
                    n_rem = rem_sh[7:0];
                end
            end
            S_MUL: begin
                n_o_nonce = r_nonce;
                n_o_slot  = r_rem;
                n_o_delay = 24'(r_rem) * 24'(r_duration);
            end
            S_OUT: begin
                if (out_beat) begin
                    n_count      = 4'd0;
                    n_crc        = CRC_INIT;
                    n_held0      = 8'd0;
                    n_held1      = 8'd0;
                    n_flags      = 5'd0;
                    n_nonce      = 16'd0;
                    n_slot_count = 8'd0;
                    n_duration   = 16'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mac        <= 48'd0;
            r_count      <= 4'd0;
            r_crc        <= CRC_INIT;
            r_held0      <= 8'd0;
            r_held1      <= 8'd0;
            r_flags      <= 5'd0;
            r_nonce      <= 16'd0;
            r_slot_count <= 8'd0;
            r_duration   <= 16'd0;
            r_last_nonce <= 16'd0;
            r_last_valid <= 1'b0;
            r_accept     <= 32'd0;
            r_cnt        <= 4'd0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) r_mac <= i_cfg_data;
            r_count      <= n_count;
            r_crc        <= n_crc;
            r_held0      <= n_held0;
            r_held1      <= n_held1;
            r_flags      <= n_flags;
            r_nonce      <= n_nonce;
            r_slot_count <= n_slot_count;
            r_duration   <= n_duration;
            r_last_nonce <= n_last_nonce;
            r_last_valid <= n_last_valid;
            r_accept     <= n_accept;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_o_status <= n_o_status;
        r_o_nonce  <= n_o_nonce;
        r_o_slot   <= n_o_slot;
        r_o_delay  <= n_o_delay;
        r_o_gen    <= n_o_gen;
    end

    assign o_status     = r_o_status;
    assign o_nonce      = r_o_nonce;
    assign o_slot       = r_o_slot;
    assign o_delay_ms   = r_o_delay;
    assign o_generation = r_o_gen;

endmodule

FILE: hdl/dsc_checker.sv
module dsc_checker
    import dsc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_frame_end,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [15:0] o_nonce,
    input logic [7:0]  o_slot,
    input logic [23:0] o_delay_ms
);

    // A result beat that is stalled stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped while stalled");

    // No byte is taken while a result is pending.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while a result is pending");

    // The last byte of a frame closes the input until its result is taken.
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_frame_end |=> !o_ready)
        else $error("ready right after the frame end beat");

    // Rejected frames carry no nonce, slot or delay.
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_ACCEPTED |->
            o_nonce == 16'd0 && o_slot == 8'd0 && o_delay_ms == 24'd0)
        else $error("rejected frame with nonzero fields");

    // Status is one of the defined codes.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_ACCEPTED)
        else $error("undefined status code");

endmodule

bind discovery_request_slot_checker_core dsc_checker u_dsc_checker (.*);

FILE: test/tb_top.sv
module tb_top
    import dsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD = 400;
    localparam int PHASE_BEATS = 400;
    localparam logic [3:0] NO_FLIP = 4'd15;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] nonce;
        logic [7:0]  slot;
        logic [23:0] delay;
        logic [31:0] generation;
    } t_slot_report;

    typedef struct packed {
        logic [15:0] nonce;
        logic [7:0]  slots;
        logic [15:0] duration;
        logic [4:0]  len;
        logic [3:0]  flip_at;
        logic [7:0]  flip_mask;
        logic        typed;
        logic [2:0]  status;
    } t_frame_row;

    localparam t_frame_row DIRECTED [0:21] = '{
        '{16'h0000, 8'd1, 16'd1, 5'd1, NO_FLIP, 8'h00, 1'b1, ST_NOT_DISCOVERY},
        '{16'h0000, 8'd1, 16'd1, 5'd2, NO_FLIP, 8'h00, 1'b1, ST_BAD_FORMAT},
        '{16'h0000, 8'd1, 16'd1, 5'd12, 4'd0, 8'hFF, 1'b1, ST_NOT_DISCOVERY},
        '{16'h0000, 8'd1, 16'd1, 5'd12, 4'd1, 8'h01, 1'b1, ST_NOT_DISCOVERY},
        '{16'h0000, 8'd1, 16'd1, 5'd12, 4'd2, 8'h02, 1'b1, ST_BAD_FORMAT},
        '{16'h0000, 8'd1, 16'd1, 5'd12, 4'd3, 8'h80, 1'b1, ST_BAD_FORMAT},
        '{16'h0000, 8'd1, 16'd1, 5'd12, 4'd4, 8'h04, 1'b1, ST_BAD_FORMAT},
        '{16'h0000, 8'd1, 16'd1, 5'd11, NO_FLIP, 8'h00, 1'b1, ST_BAD_FORMAT},
        '{16'h0000, 8'd1, 16'd1, 5'd13, NO_FLIP, 8'h00, 1'b1, ST_BAD_FORMAT},
        '{16'h0000, 8'd1, 16'd1, 5'd15, NO_FLIP, 8'h00, 1'b1, ST_BAD_FORMAT},
        '{16'h0000, 8'd1, 16'd1, 5'd20, NO_FLIP, 8'h00, 1'b1, ST_BAD_FORMAT},
        '{16'h0000, 8'd1, 16'd1, 5'd12, 4'd5, 8'h01, 1'b1, ST_CRC_ERROR},
        '{16'h0000, 8'd1, 16'd1, 5'd12, 4'd10, 8'hFF, 1'b1, ST_CRC_ERROR},
        '{16'h0000, 8'd1, 16'd1, 5'd12, 4'd11, 8'h80, 1'b1, ST_CRC_ERROR},
        '{16'h0000, 8'd0, 16'd1, 5'd12, NO_FLIP, 8'h00, 1'b1, ST_BAD_SLOTS},
        '{16'h0000, 8'd1, 16'd0, 5'd12, NO_FLIP, 8'h00, 1'b1, ST_BAD_SLOTS},
        '{16'h0000, 8'd1, 16'd1, 5'd12, NO_FLIP, 8'h00, 1'b0, ST_ACCEPTED},
        '{16'h0000, 8'd1, 16'd1, 5'd12, NO_FLIP, 8'h00, 1'b1, ST_DUPLICATE},
        '{16'hFFFF, 8'hFF, 16'hFFFF, 5'd12, NO_FLIP, 8'h00, 1'b0, ST_ACCEPTED},
        '{16'hFFFF, 8'd7, 16'd3, 5'd12, NO_FLIP, 8'h00, 1'b1, ST_DUPLICATE},
        '{16'h8001, 8'd200, 16'd1000, 5'd12, NO_FLIP, 8'h00, 1'b0, ST_ACCEPTED},
        '{16'h1234, 8'd2, 16'h8000, 5'd12, NO_FLIP, 8'h00, 1'b0, ST_ACCEPTED}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [47:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_frame_end = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_nonce;
    logic [7:0]  o_slot;
    logic [23:0] o_delay_ms;
    logic [31:0] o_generation;

    logic [3:0]  frame_len = '0;
    logic [15:0] frame_crc = CRC_INIT;
    logic [7:0]  tail_bytes [2] = '{8'h00, 8'h00};
    logic [4:0]  hdr_ok = '0;
    logic [15:0] req_nonce = '0;
    logic [7:0]  req_slots = '0;
    logic [15:0] req_duration = '0;
    logic [15:0] prev_nonce = '0;
    logic        prev_nonce_ok = 1'b0;
    logic [31:0] accepted_total = '0;
    logic [47:0] mac_value = '0;

    t_slot_report pending_reports [$];
    logic [7:0]   frame_bytes [$];
    int           status_seen [0:7] = '{default: 0};
    int           beats_in = 0;
    int           beats_out = 0;
    int           errors = 0;
    int           hold_left = 0;
    int           quiet = 0;
    bit           idle_on = 1'b1;

    discovery_request_slot_checker_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_frame_end  (i_frame_end),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_nonce      (o_nonce),
        .o_slot       (o_slot),
        .o_delay_ms   (o_delay_ms),
        .o_generation (o_generation)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic last);
        t_slot_report r;
        logic [15:0]  h;
        case (frame_len)
            4'd0: if (b == HDR0) hdr_ok[0] = 1'b1;
            4'd1: if (b == HDR1) hdr_ok[1] = 1'b1;
            4'd2: if (b == VER_OK) hdr_ok[2] = 1'b1;
            4'd3: if (b == CMD_REQ) hdr_ok[3] = 1'b1;
            4'd4: if (b == PAYLOAD_LEN) hdr_ok[4] = 1'b1;
            4'd5: req_nonce[15:8] = b;
            4'd6: req_nonce[7:0] = b;
            4'd7: req_slots = b;
            4'd8: req_duration[15:8] = b;
            4'd9: req_duration[7:0] = b;
            default: ;
        endcase
        if (frame_len >= 4'd2) begin
            frame_crc = crc_byte(frame_crc, tail_bytes[0]);
        end
        tail_bytes[0] = tail_bytes[1];
        tail_bytes[1] = b;
        if (frame_len < COUNT_MAX) begin
            frame_len++;
        end
        if (last) begin
            r = '0;
            if (frame_len < 4'd2 || hdr_ok[1:0] != 2'b11) begin
                r.status = ST_NOT_DISCOVERY;
            end else if (frame_len != REQ_LEN || hdr_ok != ALL_FLAGS) begin
                r.status = ST_BAD_FORMAT;
            end else if ({tail_bytes[1], tail_bytes[0]} != frame_crc) begin
                r.status = ST_CRC_ERROR;
            end else if (req_slots == 8'h00 || req_duration == 16'h0000) begin
                r.status = ST_BAD_SLOTS;
            end else if (prev_nonce_ok && req_nonce == prev_nonce) begin
                r.status = ST_DUPLICATE;
            end else begin
                r.status = ST_ACCEPTED;
                prev_nonce = req_nonce;
                prev_nonce_ok = 1'b1;
                accepted_total++;
                h = CRC_INIT;
                for (int i = 5; i >= 0; i--) begin
                    h = crc_byte(h, mac_value[8*i +: 8]);
                end
                h = crc_byte(h, req_nonce[15:8]);
                h = crc_byte(h, req_nonce[7:0]);
                r.nonce = req_nonce;
                r.slot = 8'(h % req_slots);
                r.delay = r.slot * req_duration;
            end
            r.generation = accepted_total;
            pending_reports.push_back(r);
            status_seen[r.status]++;
            frame_len = '0;
            frame_crc = CRC_INIT;
            tail_bytes[0] = 8'h00;
            tail_bytes[1] = 8'h00;
            hdr_ok = '0;
            req_nonce = '0;
            req_slots = '0;
            req_duration = '0;
        end
    endtask

    task automatic offer_byte(input logic [7:0] b, input logic last);
        while (idle_on && $urandom_range(99) < 12) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_frame_end <= last;
        do @(posedge i_clk); while (!o_ready);
        beats_in++;
        predict_byte(b, last);
    endtask

    task automatic build_request(input logic [15:0] nonce, input logic [7:0] slots,
                                 input logic [15:0] duration);
        logic [15:0] c;
        frame_bytes.delete();
        frame_bytes.push_back(HDR0);
        frame_bytes.push_back(HDR1);
        frame_bytes.push_back(VER_OK);
        frame_bytes.push_back(CMD_REQ);
        frame_bytes.push_back(PAYLOAD_LEN);
        frame_bytes.push_back(nonce[15:8]);
        frame_bytes.push_back(nonce[7:0]);
        frame_bytes.push_back(slots);
        frame_bytes.push_back(duration[15:8]);
        frame_bytes.push_back(duration[7:0]);
        c = CRC_INIT;
        foreach (frame_bytes[k]) begin
            c = crc_byte(c, frame_bytes[k]);
        end
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
    endtask

    task automatic reshape(input int len, input int flip_at, input logic [7:0] mask);
        if (flip_at < frame_bytes.size()) begin
            frame_bytes[flip_at] = frame_bytes[flip_at] ^ mask;
        end
        while (frame_bytes.size() > len) begin
            void'(frame_bytes.pop_back());
        end
        while (frame_bytes.size() < len) begin
            frame_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic send_frame();
        foreach (frame_bytes[k]) begin
            offer_byte(frame_bytes[k], k == frame_bytes.size() - 1);
        end
    endtask

    task automatic set_mac(input logic [47:0] value);
        i_valid <= 1'b0;
        wait (pending_reports.size() == 0);
        repeat (30) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mac_value = value;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, what, want, got);
        errors++;
    endtask

    initial begin
        t_slot_report want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t ns: result beat with none pending, %s %0d",
                             $time, "expected nothing, actual status", o_status);
                    errors++;
                end else begin
                    want = pending_reports.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch("status", want.status, o_status);
                    end
                    if (o_nonce !== want.nonce) report_mismatch("nonce", want.nonce, o_nonce);
                    if (o_slot !== want.slot) report_mismatch("slot", want.slot, o_slot);
                    if (o_delay_ms !== want.delay) begin
                        report_mismatch("delay", want.delay, o_delay_ms);
                    end
                    if (o_generation !== want.generation) begin
                        report_mismatch("generation", want.generation, o_generation);
                    end
                end
                beats_out++;
                if (beats_out == 30 || beats_out == 100) begin
                    hold_left = LONG_HOLD;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !(idle_on && $urandom_range(99) < 12);
            end
        end
    end

    initial begin
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t ns: no beat for %0d cycles", $time, quiet);
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_slot_report typed_rep;
        logic [15:0]  n;
        logic [7:0]   s;
        logic [15:0]  d;
        int           pick;
        int           target;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r]) begin
            build_request(DIRECTED[r].nonce, DIRECTED[r].slots, DIRECTED[r].duration);
            reshape(DIRECTED[r].len, DIRECTED[r].flip_at, DIRECTED[r].flip_mask);
            send_frame();
            if (DIRECTED[r].typed) begin
                typed_rep = pending_reports.pop_back();
                typed_rep.status = DIRECTED[r].status;
                typed_rep.nonce = '0;
                typed_rep.slot = '0;
                typed_rep.delay = '0;
                pending_reports.push_back(typed_rep);
            end
        end

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: set_mac(48'hFFFF_FFFF_FFFF);
                1: set_mac({16'($urandom), 32'($urandom)});
                2: set_mac(48'h0000_0000_0000);
                3: set_mac({16'($urandom), 32'($urandom)});
                default: set_mac(48'h8000_0000_0001);
            endcase
            idle_on = (p != 2);
            target = beats_in + PHASE_BEATS;
            while (beats_in < target) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    frame_bytes.delete();
                    repeat ($urandom_range(1, 16)) frame_bytes.push_back(8'($urandom));
                end else begin
                    n = ($urandom_range(9) == 0) ? prev_nonce : 16'($urandom);
                    s = ($urandom_range(11) == 0) ? 8'h00 : 8'($urandom);
                    d = ($urandom_range(11) == 0) ? 16'h0000 : 16'($urandom);
                    build_request(n, s, d);
                    pick = $urandom_range(99);
                    if (pick < 6) begin
                        reshape(12, $urandom_range(11), 8'($urandom_range(1, 255)));
                    end else if (pick < 12) begin
                        reshape($urandom_range(1, 18), NO_FLIP, 8'h00);
                    end
                end
                send_frame();
            end
        end
        idle_on = 1'b1;

        i_valid <= 1'b0;
        wait (pending_reports.size() == 0);
        repeat (40) @(posedge i_clk);

        $display("Checked %0d result beats from %0d byte beats over six MAC settings,",
                 beats_out, beats_in);
        $display("with two long output stalls.");
        $display("Accepted %0d, duplicate %0d, CRC error %0d, bad slots %0d,",
                 status_seen[ST_ACCEPTED], status_seen[ST_DUPLICATE],
                 status_seen[ST_CRC_ERROR], status_seen[ST_BAD_SLOTS]);
        $display("bad format %0d, not discovery %0d.",
                 status_seen[ST_BAD_FORMAT], status_seen[ST_NOT_DISCOVERY]);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
